// ----- hdl/mwc_pkg.sv -----
// ----------------------------------------------------------------------------
// mwc_pkg
// Shared codes and fixed widths of the minimum window cover finder.
// ----------------------------------------------------------------------------
package mwc_pkg;

    localparam int SYM_BITS = 7;
    localparam int POS_BITS = 16;
    localparam int LEN_BITS = 17;

    localparam logic [1:0] OP_PATTERN = 2'd0;
    localparam logic [1:0] OP_TEXT    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_NEED   = 2'd1;
    localparam logic [1:0] ERR_LENGTH = 2'd2;

endpackage

// ----- hdl/minimum_window_cover_finder.sv -----
// ----------------------------------------------------------------------------
// minimum_window_cover_finder
// Shortest text window covering a pattern, one transaction at a time.
// ----------------------------------------------------------------------------
// Restarts and ignored items only pass decode and output; pattern loads and text
// items also read their symbol entry, and a text item that covers the pattern
// runs a rescan of every symbol through one comparator, preceded by an eviction
// when that symbol's ring is already full.
// One transaction in flight; the next is taken once it finishes.
// Reset (synchronous, active low) and the restart operation clear the pattern, text and best-window state.
module minimum_window_cover_finder #(
    parameter int ALPHABET_SIZE = 128,
    parameter int MAX_NEED      = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_operation,
    input  logic [mwc_pkg::SYM_BITS-1:0]  i_symbol,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_window_found,
    output logic [mwc_pkg::POS_BITS-1:0]  o_best_start,
    output logic [mwc_pkg::LEN_BITS-1:0]  o_best_length,
    output logic [1:0]                    o_error_code
);

    import mwc_pkg::*;

    localparam int SW  = $clog2(ALPHABET_SIZE);
    localparam int CW  = SW + 1;
    localparam int HW  = (MAX_NEED > 1) ? $clog2(MAX_NEED) : 1;
    localparam int NW  = $clog2(MAX_NEED + 1);
    localparam int DW  = $clog2(ALPHABET_SIZE + 1);
    localparam int WW  = NW + NW + HW;
    localparam int RD  = ALPHABET_SIZE * MAX_NEED;
    localparam int RAW = $clog2(RD);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_SYM   = 3'd2;
    localparam logic [2:0] S_EVICT = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_JUDGE = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]          r_state;
    logic [1:0]          r_op;
    logic [SYM_BITS-1:0] r_sym;
    logic [DW-1:0]       r_distinct;
    logic [DW-1:0]       r_sat;
    logic [POS_BITS:0]   r_text_pos;
    logic [POS_BITS-1:0] r_pos;
    logic [POS_BITS-1:0] r_cur_start;
    logic [POS_BITS-1:0] r_best_start;
    logic [LEN_BITS-1:0] r_best_len;
    logic                r_found;
    logic [1:0]          r_err;
    logic [CW-1:0]       r_scan_idx;
    logic                r_s1_valid;
    logic [SW-1:0]       r_s1_idx;
    logic                r_s2_valid;
    logic [POS_BITS-1:0] r_least;
    logic                r_out_valid;

    logic [8:0]          sym_ext;
    logic                in_alpha;
    logic [SW-1:0]       sym_idx;
    logic                sym_clear;
    logic                sym_we;
    logic [WW-1:0]       sym_wdata;
    logic [SW-1:0]       sym_raddr;
    logic [WW-1:0]       sym_rdata;
    logic [NW-1:0]       rd_need;
    logic [NW-1:0]       rd_fill;
    logic [HW-1:0]       rd_head;
    logic                ring_we;
    logic [RAW-1:0]      ring_waddr;
    logic [RAW-1:0]      ring_raddr;
    logic [POS_BITS-1:0] ring_rdata;
    logic [NW:0]         sum_fill;
    logic [NW:0]         sum_need;
    logic [NW:0]         sum_one;
    logic [HW-1:0]       slot_fill;
    logic [HW-1:0]       slot_need;
    logic [HW-1:0]       head_next;
    logic [RAW-1:0]      sym_base;
    logic [RAW-1:0]      scan_base;
    logic [DW-1:0]       sat_inc;
    logic [LEN_BITS-1:0] cand_len;
    logic                accept;
    logic                out_free;

    assign sym_ext  = 9'(r_sym);
    assign in_alpha = sym_ext < 9'(ALPHABET_SIZE);
    assign sym_idx  = sym_ext[SW-1:0];

    assign rd_need = sym_rdata[WW-1 -: NW];
    assign rd_fill = sym_rdata[HW+NW-1 -: NW];
    assign rd_head = sym_rdata[HW-1:0];

    // Ring slots wrap modulo the ring depth; sums stay below twice the depth.
    assign sum_fill  = (NW+1)'(rd_head) + (NW+1)'(rd_fill);
    assign sum_need  = (NW+1)'(rd_head) + (NW+1)'(rd_need);
    assign sum_one   = (NW+1)'(rd_head) + (NW+1)'(1);
    assign slot_fill = HW'((sum_fill >= (NW+1)'(MAX_NEED)) ? sum_fill - (NW+1)'(MAX_NEED)
                                                           : sum_fill);
    assign slot_need = HW'((sum_need >= (NW+1)'(MAX_NEED)) ? sum_need - (NW+1)'(MAX_NEED)
                                                           : sum_need);
    assign head_next = HW'((sum_one >= (NW+1)'(MAX_NEED)) ? sum_one - (NW+1)'(MAX_NEED)
                                                          : sum_one);

    assign sym_base  = RAW'(sym_idx) * RAW'(MAX_NEED);
    assign scan_base = RAW'(r_s1_idx) * RAW'(MAX_NEED);
    assign sat_inc   = r_sat + DW'(1);
    assign cand_len  = LEN_BITS'(r_pos) - LEN_BITS'(r_least) + LEN_BITS'(1);

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        sym_clear  = (r_state == S_DEC) && (r_op == OP_RESTART);
        sym_we     = 1'b0;
        sym_wdata  = sym_rdata;
        sym_raddr  = (r_state == S_SCAN) ? r_scan_idx[SW-1:0] : sym_idx;
        ring_we    = 1'b0;
        ring_waddr = sym_base + RAW'(slot_fill);
        ring_raddr = (r_state == S_SCAN) ? scan_base + RAW'(rd_head)
                                         : sym_base + RAW'(rd_head);
        case (r_state)
            S_SYM: begin
                if (r_op == OP_PATTERN) begin
                    sym_we    = rd_need < NW'(MAX_NEED);
                    sym_wdata = {rd_need + NW'(1), rd_fill, rd_head};
                end else if (rd_need != '0 && rd_fill < rd_need) begin
                    sym_we    = 1'b1;
                    sym_wdata = {rd_need, rd_fill + NW'(1), rd_head};
                    ring_we   = 1'b1;
                end
            end
            S_EVICT: begin
                sym_we     = 1'b1;
                sym_wdata  = {rd_need, rd_fill, head_next};
                ring_we    = 1'b1;
                ring_waddr = sym_base + RAW'(slot_need);
            end
            default: begin
            end
        endcase
    end

    mwc_sym_ram #(
        .DEPTH (ALPHABET_SIZE),
        .AW    (SW),
        .DW    (WW)
    ) u_sym_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (sym_clear),
        .i_we    (sym_we),
        .i_waddr (sym_idx),
        .i_wdata (sym_wdata),
        .i_raddr (sym_raddr),
        .o_rdata (sym_rdata)
    );

    mwc_ring_ram #(
        .DEPTH (RD),
        .AW    (RAW),
        .DW    (POS_BITS)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (r_pos),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_op         <= OP_PATTERN;
            r_sym        <= '0;
            r_distinct   <= '0;
            r_sat        <= '0;
            r_text_pos   <= '0;
            r_pos        <= '0;
            r_cur_start  <= '0;
            r_best_start <= '0;
            r_best_len   <= '0;
            r_found      <= 1'b0;
            r_err        <= ERR_NONE;
            r_scan_idx   <= '0;
            r_s1_valid   <= 1'b0;
            r_s1_idx     <= '0;
            r_s2_valid   <= 1'b0;
            r_least      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= i_operation;
                        r_sym   <= i_symbol;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_state <= S_OUT;
                    case (r_op)
                        OP_RESTART: begin
                            r_distinct   <= '0;
                            r_sat        <= '0;
                            r_text_pos   <= '0;
                            r_cur_start  <= '0;
                            r_best_start <= '0;
                            r_best_len   <= '0;
                            r_found      <= 1'b0;
                            r_err        <= ERR_NONE;
                        end
                        OP_PATTERN: begin
                            if (r_text_pos == '0 && in_alpha) begin
                                r_state <= S_SYM;
                            end
                        end
                        OP_TEXT: begin
                            if (r_text_pos[POS_BITS]) begin
                                if (r_err == ERR_NONE) begin
                                    r_err <= ERR_LENGTH;
                                end
                            end else begin
                                r_pos      <= r_text_pos[POS_BITS-1:0];
                                r_text_pos <= r_text_pos + (POS_BITS+1)'(1);
                                if (in_alpha) begin
                                    r_state <= S_SYM;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_SYM: begin
                    r_state <= S_OUT;
                    if (r_op == OP_PATTERN) begin
                        if (rd_need >= NW'(MAX_NEED)) begin
                            if (r_err == ERR_NONE) begin
                                r_err <= ERR_NEED;
                            end
                        end else if (rd_need == '0) begin
                            r_distinct <= r_distinct + DW'(1);
                        end
                    end else if (rd_need != '0) begin
                        if (rd_fill < rd_need) begin
                            if (rd_fill + NW'(1) == rd_need) begin
                                r_sat <= sat_inc;
                                if (sat_inc == r_distinct) begin
                                    r_state <= S_SCAN;
                                end
                            end
                        end else begin
                            r_state <= S_EVICT;
                        end
                    end
                end
                S_EVICT: begin
                    // Rescan only when all symbols are satisfied and the evicted position was the window start.
                    if (r_sat == r_distinct && r_cur_start == ring_rdata) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SCAN: begin
                    if (r_scan_idx < CW'(ALPHABET_SIZE)) begin
                        r_s1_valid <= 1'b1;
                        r_s1_idx   <= r_scan_idx[SW-1:0];
                        r_scan_idx <= r_scan_idx + CW'(1);
                    end else begin
                        r_s1_valid <= 1'b0;
                    end
                    r_s2_valid <= r_s1_valid && (rd_need != '0);
                    if (r_s2_valid && ring_rdata < r_least) begin
                        r_least <= ring_rdata;
                    end
                    if (r_scan_idx == CW'(ALPHABET_SIZE) && !r_s1_valid && !r_s2_valid) begin
                        r_state <= S_JUDGE;
                    end
                end
                S_JUDGE: begin
                    r_cur_start <= r_least;
                    if (!r_found || cand_len < r_best_len) begin
                        r_best_len   <= cand_len;
                        r_best_start <= r_least;
                        r_found      <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // Arm the rescan whenever it is entered.
            if (r_state != S_SCAN) begin
                r_scan_idx <= '0;
                r_s1_valid <= 1'b0;
                r_s2_valid <= 1'b0;
                r_least    <= '1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            o_window_found <= r_found;
            o_best_start   <= r_best_start;
            o_best_length  <= r_best_len;
            o_error_code   <= r_err;
        end
    end

    assign o_valid = r_out_valid;
    assign o_stall = (r_state != S_IDLE);

endmodule

// ----- hdl/mwc_sym_ram.sv -----
// ----------------------------------------------------------------------------
// mwc_sym_ram
// Per-symbol need/fill/head memory; entries without a valid bit read as zero.
// ----------------------------------------------------------------------------
module mwc_sym_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DW-1:0]    r_rdata;
    logic             r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// ----- hdl/mwc_ring_ram.sv -----
// ----------------------------------------------------------------------------
// mwc_ring_ram
// Position ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mwc_ring_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for minimum_window_cover_finder: pattern loads, text and
// restarts are driven with random idling, and every result is checked against
// a shortest-window predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mwc_pkg::*;

    localparam int ALPHA     = 128;
    localparam int DEPTH     = 16;
    localparam int TEXT_MAX  = 65536;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]          op;
        logic [SYM_BITS-1:0] sym;
    } txn_t;

    typedef struct packed {
        logic                found;
        logic [POS_BITS-1:0] start;
        logic [LEN_BITS-1:0] length;
        logic [1:0]          err;
    } window_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_operation = '0;
    logic [SYM_BITS-1:0] i_symbol = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_window_found;
    logic [POS_BITS-1:0] o_best_start;
    logic [LEN_BITS-1:0] o_best_length;
    logic [1:0] o_error_code;

    minimum_window_cover_finder dut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // predictor state
    int        need[ALPHA];
    int        fill[ALPHA];
    int        head[ALPHA];
    int        ring[ALPHA][DEPTH];
    int        distinct_cnt, satisfied_cnt;
    longint    text_pos, win_start, best_start, best_len;
    bit        found;
    logic [1:0] err_code;

    txn_t    pending_txns[$];
    window_t expected_windows[$];
    int  failures = 0;
    bit  quiet = 1'b0;

    function automatic void clear_finder();
        for (int s = 0; s < ALPHA; s++) begin
            need[s] = 0; fill[s] = 0; head[s] = 0;
        end
        distinct_cnt = 0; satisfied_cnt = 0; text_pos = 0; win_start = 0;
        best_start = 0; best_len = 0; found = 1'b0; err_code = ERR_NONE;
    endfunction

    function automatic void flag_error(logic [1:0] code);
        if (err_code == ERR_NONE) err_code = code;
    endfunction

    function automatic void judge(longint pos);
        longint least;
        longint len;
        least = TEXT_MAX - 1;
        for (int s = 0; s < ALPHA; s++)
            if (need[s] != 0 && ring[s][head[s]] < least) least = ring[s][head[s]];
        win_start = least;
        len = pos - least + 1;
        if (!found || len < best_len) begin
            best_len = len; best_start = least; found = 1'b1;
        end
    endfunction

    function automatic window_t predict_window(txn_t t);
        window_t w;
        longint pos;
        int s, slot;
        longint evicted;
        s = t.sym;
        case (t.op)
            OP_PATTERN: begin
                if (text_pos == 0) begin
                    if (need[s] >= DEPTH) flag_error(ERR_NEED);
                    else begin
                        if (need[s] == 0) distinct_cnt++;
                        need[s]++;
                    end
                end
            end
            OP_TEXT: begin
                if (text_pos >= TEXT_MAX) flag_error(ERR_LENGTH);
                else begin
                    pos = text_pos;
                    text_pos++;
                    if (need[s] != 0) begin
                        if (fill[s] < need[s]) begin
                            slot = (head[s] + fill[s]) % DEPTH;
                            ring[s][slot] = int'(pos);
                            fill[s]++;
                            if (fill[s] == need[s]) begin
                                satisfied_cnt++;
                                if (satisfied_cnt == distinct_cnt) judge(pos);
                            end
                        end else begin
                            evicted = ring[s][head[s]];
                            slot = (head[s] + need[s]) % DEPTH;
                            ring[s][slot] = int'(pos);
                            head[s] = (head[s] + 1) % DEPTH;
                            if (satisfied_cnt == distinct_cnt && win_start == evicted)
                                judge(pos);
                        end
                    end
                end
            end
            OP_RESTART: clear_finder();
            default: ;
        endcase
        w.found = found;
        w.start = best_start[POS_BITS-1:0];
        w.length = best_len[LEN_BITS-1:0];
        w.err = err_code;
        return w;
    endfunction

    function automatic void push(logic [1:0] op, int sym);
        txn_t t;
        t.op = op;
        t.sym = sym[SYM_BITS-1:0];
        pending_txns.insert(pending_txns.size(), t);
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!(i_valid && o_stall)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_txns.size() > 0 && !(quiet == 0 &&
                             $urandom_range(0, 9) == 0 && !i_valid)) begin
                    txn_t t;
                    t = pending_txns.pop_front();
                    expected_windows.insert(expected_windows.size(), predict_window(t));
                    i_operation <= t.op;
                    i_symbol <= t.sym;
                    i_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 10);
                end else begin
                    i_valid <= 1'b0;
                    if (!quiet && pending_txns.size() > 0)
                        send_gap <= $urandom_range(1, 10);
                end
            end
        end
    end

    // monitor
    int recv_gap = 0;
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_valid && !i_stall) begin
                if (expected_windows.size() == 0) begin
                    $error("result with nothing expected");
                    failures++;
                end else begin
                    window_t e;
                    e = expected_windows.pop_front();
                    if (o_window_found !== e.found) begin
                        $error("window_found exp %0d got %0d", e.found, o_window_found);
                        failures++;
                    end
                    if (o_best_start !== e.start) begin
                        $error("best_start exp %0d got %0d", e.start, o_best_start);
                        failures++;
                    end
                    if (o_best_length !== e.length) begin
                        $error("best_length exp %0d got %0d", e.length, o_best_length);
                        failures++;
                    end
                    if (o_error_code !== e.err) begin
                        $error("error_code exp %0d got %0d", e.err, o_error_code);
                        failures++;
                    end
                end
            end
            if (quiet) i_stall <= 1'b0;
            else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(0, 9);
                i_stall <= 1'b1;
            end else i_stall <= 1'b0;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // random pattern of n symbols drawn from a small alphabet starting at base
    task automatic random_scenario(int n_pat, int n_txt, int span);
        int base;
        base = $urandom_range(0, ALPHA - span);
        push(OP_RESTART, $urandom_range(0, 127));
        for (int k = 0; k < n_pat; k++) push(OP_PATTERN, base + $urandom_range(0, span - 1));
        for (int k = 0; k < n_txt; k++) begin
            case ($urandom_range(0, 19))
                0: push(OP_PATTERN, $urandom_range(0, 127));
                1: push(2'd3, $urandom_range(0, 127));
                2: push(OP_TEXT, $urandom_range(0, 127));
                default: push(OP_TEXT, base + $urandom_range(0, span - 1));
            endcase
        end
    endtask

    initial begin
        int sent;
        clear_finder();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, overflow of need, ignored ops, ties
        push(OP_TEXT, 0);
        push(OP_RESTART, 127);
        push(OP_PATTERN, 0);
        push(OP_PATTERN, 127);
        push(OP_PATTERN, 127);
        push(2'd3, 85);
        push(OP_TEXT, 127);
        push(OP_TEXT, 42);
        push(OP_TEXT, 0);
        push(OP_TEXT, 127);
        push(OP_PATTERN, 5);
        push(OP_TEXT, 0);
        push(OP_TEXT, 127);
        push(OP_TEXT, 127);
        push(OP_TEXT, 0);
        push(OP_RESTART, 0);
        for (int k = 0; k < 17; k++) push(OP_PATTERN, 85);
        push(OP_TEXT, 42);
        push(OP_RESTART, 42);
        sent = pending_txns.size();
        while (sent < 1280) begin
            int np, nt;
            np = $urandom_range(1, 6);
            nt = $urandom_range(10, 60);
            random_scenario(np, nt, $urandom_range(2, 8));
            sent += 1 + np + nt;
        end
        // deep ring: one symbol needed sixteen times, plus a second symbol
        push(OP_RESTART, 0);
        for (int k = 0; k < 16; k++) push(OP_PATTERN, 127);
        push(OP_PATTERN, 0);
        for (int k = 0; k < 60; k++) push(OP_TEXT, $urandom_range(0, 1) ? 127 : 0);
        // closing run with no idling
        wait (pending_txns.size() == 0);
        quiet = 1'b1;
        push(OP_RESTART, 0);
        push(OP_PATTERN, 7);
        for (int k = 0; k < 40; k++)
            push(OP_TEXT, (k % 8 == 0) ? 7 : $urandom_range(0, 127) & 7'h3f);
        wait (pending_txns.size() == 0 && expected_windows.size() == 0);
        repeat (200) @(posedge i_clk);
        if (failures == 0 && expected_windows.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
